FILE: sv/mmix_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mecanum wheel mixer.
// No dependencies.
package mmix_pkg;

	localparam int unsigned NUM_WHEELS = 4;
	localparam int unsigned Q_DEPTH    = 2;
	localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int unsigned QUOT_W     = 15;
	localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W);

	localparam logic [14:0] VX_LIMIT_RST    = 15'd10000;
	localparam logic [14:0] VY_LIMIT_RST    = 15'd10000;
	localparam logic [14:0] WZ_LIMIT_RST    = 15'd8000;
	localparam logic [14:0] WHEEL_LIMIT_RST = 15'd19000;
	localparam logic [7:0]  RAMP_STEP_RST   = 8'd3;

	typedef enum logic [2:0] {
		CFG_VX_LIMIT    = 3'd0,
		CFG_VY_LIMIT    = 3'd1,
		CFG_WZ_LIMIT    = 3'd2,
		CFG_WHEEL_LIMIT = 3'd3,
		CFG_RAMP_STEP   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [14:0] vx_limit;
		logic [14:0] vy_limit;
		logic [14:0] wz_limit;
		logic [14:0] wheel_limit;
		logic [7:0]  ramp_step;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [15:0] vx_target;
		logic signed [15:0] vy_target;
		logic signed [15:0] wz_target;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] wheel_0;
		logic signed [15:0] wheel_1;
		logic signed [15:0] wheel_2;
		logic signed [15:0] wheel_3;
		logic               scaled_down;
		logic signed [15:0] vx_ramped;
		logic signed [15:0] vy_ramped;
	} out_item_t;

	// one classified item between front and back
	typedef struct packed {
		logic [NUM_WHEELS-1:0][16:0] mag;
		logic [NUM_WHEELS-1:0]       neg;
		logic [16:0]                 mx;
		logic                        scaled;
		logic signed [15:0]          vx_ramped;
		logic signed [15:0]          vy_ramped;
	} mix_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

FILE: sv/mecanum_wheel_mixer.sv
`timescale 1ns / 1ps
// Mecanum wheel mixer top: config registers, front, queue and back.
// Depends on mmix_pkg, mmix_front, mmix_fifo, mmix_back.
//
// Usage:
//  in channel (in_valid/in_ready/in_item): one beat carries vx, vy, wz targets.
//  out channel (out_valid/out_ready/out_item): one beat per input beat, in order,
//   with four wheel speeds, the scaled_down flag and the ramped vx/vy copies.
//  cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0..4
//   selects vx_limit, vy_limit, wz_limit, wheel_limit, ramp_step. Other indexes
//   are dropped. Write only while the block is idle.
//  The back end takes one item at a time, through its 15-step restoring divider when
//   scaling applies (four lanes sharing the max divisor), and takes no new item
//   until the last one has been loaded into the output register.
//  The front keeps accepting into a two-entry queue while the back works or the
//  output beat is stalled; when the queue fills, in_ready drops. A stalled output
//  beat holds in its register until out_ready.
//  Reset: registers return to their defaults, ramp state to zero, queue empty.
module mecanum_wheel_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mmix_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mmix_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	mmix_pkg::cfg_regs_t  cfg_q;
	mmix_pkg::mix_entry_t f_entry, q_data;
	mmix_pkg::q_status_t  q_stat;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vx_limit    <= mmix_pkg::VX_LIMIT_RST;
			cfg_q.vy_limit    <= mmix_pkg::VY_LIMIT_RST;
			cfg_q.wz_limit    <= mmix_pkg::WZ_LIMIT_RST;
			cfg_q.wheel_limit <= mmix_pkg::WHEEL_LIMIT_RST;
			cfg_q.ramp_step   <= mmix_pkg::RAMP_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mmix_pkg::cfg_idx_t'(cfg_index))
				mmix_pkg::CFG_VX_LIMIT:    cfg_q.vx_limit    <= cfg_data[14:0];
				mmix_pkg::CFG_VY_LIMIT:    cfg_q.vy_limit    <= cfg_data[14:0];
				mmix_pkg::CFG_WZ_LIMIT:    cfg_q.wz_limit    <= cfg_data[14:0];
				mmix_pkg::CFG_WHEEL_LIMIT: cfg_q.wheel_limit <= cfg_data[14:0];
				mmix_pkg::CFG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mmix_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_stat.full),
		.push     (push),
		.entry    (f_entry)
	);

	mmix_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (f_entry),
		.pop     (pop),
		.rd_data (q_data),
		.status  (q_stat)
	);

	mmix_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wheel_limit (cfg_q.wheel_limit),
		.q_empty     (q_stat.empty),
		.q_data      (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.scaled_down |->
			out_item.wheel_0 <= $signed({1'b0, cfg_q.wheel_limit}) &&
			out_item.wheel_0 >= -$signed({1'b0, cfg_q.wheel_limit}) &&
			out_item.wheel_3 <= $signed({1'b0, cfg_q.wheel_limit}) &&
			out_item.wheel_3 >= -$signed({1'b0, cfg_q.wheel_limit}))
		else $error("scaled wheel beyond limit");

endmodule

FILE: sv/mmix_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified items between front and back.
// Depends on mmix_pkg.
module mmix_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mmix_pkg::mix_entry_t wr_data,
	input  logic                 pop,
	output mmix_pkg::mix_entry_t rd_data,
	output mmix_pkg::q_status_t  status
);

	mmix_pkg::mix_entry_t mem_q [mmix_pkg::Q_DEPTH];
	logic [mmix_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mmix_pkg::Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == mmix_pkg::Q_CNT_W'(mmix_pkg::Q_DEPTH));
	assign status.empty = (cnt_q == '0);

endmodule

FILE: sv/mmix_front.sv
`timescale 1ns / 1ps
// Front: accepts beats, clamps targets, updates ramp state, mixes wheels, finds max.
// Depends on mmix_pkg.
module mmix_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mmix_pkg::cfg_regs_t  cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mmix_pkg::in_item_t   in_item,
	input  logic                 q_full,
	output logic                 push,
	output mmix_pkg::mix_entry_t entry
);

	function automatic logic signed [16:0] clamp_sym(logic signed [15:0] v, logic [14:0] lim);
		logic signed [16:0] x, l;
		x = 17'(v);
		l = $signed({2'b00, lim});
		if (x > l)       x = l;
		else if (x < -l) x = -l;
		return x;
	endfunction

	function automatic logic signed [15:0] ramp_next(logic signed [15:0] value,
		logic signed [16:0] target, logic [7:0] step);
		logic signed [17:0] v, t, s;
		v = 18'(value);
		t = 18'(target);
		s = $signed({10'd0, step});
		if (t > 0) begin
			if (t > v)  v = v + s;
			if (t <= v) v = t;
		end else if (t < 0) begin
			if (t < v)  v = v - s;
			if (t >= v) v = t;
		end else if (v > 0) begin
			v = (v > s) ? v - s : '0;
		end else if (v < 0) begin
			v = (-v > s) ? v + s : '0;
		end
		return v[15:0];
	endfunction

	logic signed [15:0] vx_ramp_q, vy_ramp_q;
	logic signed [15:0] vx_ramp_d, vy_ramp_d;
	logic signed [16:0] vx, vy, wz;
	logic signed [17:0] w [mmix_pkg::NUM_WHEELS];
	logic [16:0] mag [mmix_pkg::NUM_WHEELS];
	logic [16:0] mx01, mx23;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		vx = clamp_sym(in_item.vx_target, cfg.vx_limit);
		vy = clamp_sym(in_item.vy_target, cfg.vy_limit);
		wz = clamp_sym(in_item.wz_target, cfg.wz_limit);
		vx_ramp_d = ramp_next(vx_ramp_q, vx, cfg.ramp_step);
		vy_ramp_d = ramp_next(vy_ramp_q, vy, cfg.ramp_step);
		w[0] = -18'(vx) - 18'(vy) - 18'(wz);
		w[1] =  18'(vx) - 18'(vy) - 18'(wz);
		w[2] =  18'(vx) + 18'(vy) - 18'(wz);
		w[3] = -18'(vx) + 18'(vy) - 18'(wz);
		for (int i = 0; i < mmix_pkg::NUM_WHEELS; i++) begin
			mag[i] = w[i][17] ? 17'(-w[i]) : w[i][16:0];
		end
		mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
		mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
		entry.mx = (mx01 > mx23) ? mx01 : mx23;
		for (int i = 0; i < mmix_pkg::NUM_WHEELS; i++) begin
			entry.mag[i] = mag[i];
			entry.neg[i] = w[i][17];
		end
		entry.scaled    = (entry.mx > {2'b00, cfg.wheel_limit});
		entry.vx_ramped = vx_ramp_d;
		entry.vy_ramped = vy_ramp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_ramp_q <= '0;
			vy_ramp_q <= '0;
		end else if (push) begin
			vx_ramp_q <= vx_ramp_d;
			vy_ramp_q <= vy_ramp_d;
		end
	end

endmodule

FILE: sv/mmix_back.sv
`timescale 1ns / 1ps
// Back: four-lane restoring divider for proportional scaling and the output register.
// Depends on mmix_pkg.
module mmix_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [14:0]          wheel_limit,
	input  logic                 q_empty,
	input  mmix_pkg::mix_entry_t q_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mmix_pkg::out_item_t  out_item
);

	localparam int unsigned NW = mmix_pkg::NUM_WHEELS;
	localparam int unsigned QW = mmix_pkg::QUOT_W;

	mmix_pkg::bk_state_t state_q, state_d;
	mmix_pkg::mix_entry_t ent_q;
	logic [mmix_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [NW-1:0][17:0]   rem_q;
	logic [NW-1:0][QW-1:0] lo_q, quo_q;
	logic [31:0] prod [NW];
	logic [17:0] trial [NW];
	logic [15:0] res [NW];
	logic ld_mul, div_step, load_out, div_last;
	logic out_valid_q;
	mmix_pkg::out_item_t out_q;

	assign div_last = (cnt_q == mmix_pkg::DIV_CNT_W'(QW - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmix_pkg::BK_IDLE: if (!q_empty) state_d = q_data.scaled ? mmix_pkg::BK_MUL
			                                                           : mmix_pkg::BK_OUT;
			mmix_pkg::BK_MUL:  state_d = mmix_pkg::BK_DIV;
			mmix_pkg::BK_DIV:  if (div_last) state_d = mmix_pkg::BK_OUT;
			mmix_pkg::BK_OUT:  if (!out_valid_q || out_ready) state_d = mmix_pkg::BK_IDLE;
			default:           state_d = mmix_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		ld_mul   = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mmix_pkg::BK_IDLE: pop      = !q_empty;
			mmix_pkg::BK_MUL:  ld_mul   = 1'b1;
			mmix_pkg::BK_DIV:  div_step = 1'b1;
			mmix_pkg::BK_OUT:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			prod[i]  = 32'(ent_q.mag[i]) * 32'(wheel_limit);
			trial[i] = {rem_q[i][16:0], lo_q[i][QW-1]};
			if (ent_q.scaled) res[i] = {1'b0, quo_q[i]};
			else              res[i] = ent_q.mag[i][15:0];
			if (ent_q.neg[i]) res[i] = 16'd0 - res[i];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= q_data;
		if (ld_mul) begin
			for (int i = 0; i < NW; i++) begin
				rem_q[i] <= {1'b0, prod[i][31:QW]};
				lo_q[i]  <= prod[i][QW-1:0];
				quo_q[i] <= '0;
			end
		end else if (div_step) begin
			for (int i = 0; i < NW; i++) begin
				if (trial[i] >= {1'b0, ent_q.mx}) begin
					rem_q[i] <= trial[i] - {1'b0, ent_q.mx};
					quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[i];
					quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
				end
				lo_q[i] <= {lo_q[i][QW-2:0], 1'b0};
			end
		end
		if (load_out) begin
			out_q.wheel_0     <= res[0];
			out_q.wheel_1     <= res[1];
			out_q.wheel_2     <= res[2];
			out_q.wheel_3     <= res[3];
			out_q.scaled_down <= ent_q.scaled;
			out_q.vx_ramped   <= ent_q.vx_ramped;
			out_q.vy_ramped   <= ent_q.vy_ramped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmix_pkg::BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_mul)        cnt_q <= '0;
			else if (div_step) cnt_q <= cnt_q + 1'b1;
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
